>>> sv/mnpm_pkg.sv
// Shared types and constants for the mesh node presence monitor.
package mnpm_pkg;

  localparam int unsigned NodeSlots    = 16;
  localparam int unsigned ChannelCount = 8;
  localparam int unsigned WindowSlots  = 60;
  localparam int unsigned MaxResults   = 8;
  localparam int unsigned SlotW        = $clog2(NodeSlots);
  localparam int unsigned ChanW        = $clog2(ChannelCount);
  localparam int unsigned WinW         = $clog2(WindowSlots);
  // scan index must reach one past the longest scan (slots or ring)
  localparam int unsigned IdxW         = ((SlotW > WinW) ? SlotW : WinW) + 1;
  localparam int unsigned NumReports   = (ChannelCount < MaxResults) ? ChannelCount : MaxResults;

  localparam logic [23:0] ActOne = 24'h010000;
  localparam logic [23:0] ActMax = 24'hFFFFFF;

  localparam logic [1:0] CmdEvent = 2'd0;
  localparam logic [1:0] CmdSync  = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;
  localparam logic [1:0] CmdNone  = 2'd3;

  localparam logic [1:0] StMatched = 2'd0;
  localparam logic [1:0] StAdded   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StNone    = 2'd3;

  localparam logic [2:0] RegTimeout = 3'd0;
  localparam logic [2:0] RegDecay   = 3'd1;
  localparam logic [2:0] RegFloor   = 3'd2;
  localparam logic [2:0] RegSensor  = 3'd3;
  localparam logic [2:0] RegCount   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_DECAY,
    S_SENSE,
    S_AGE,
    S_RING,
    S_SUM,
    S_SCAN,
    S_OUT
  } state_e;

endpackage

>>> sv/mnpm_ram.sv
// Generic single-port RAM with registered read.
module mnpm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> sv/mesh_node_presence_monitor_core.sv
// Top level: node table, channel tallies, per-second ring and sequencer.
// Event/sync: lookup over the 16 slots, update, ring write for events, ring sum over the
// 60 entries and a 16-slot summary scan; cmd 3 and sync with id 0 skip lookup.
// Tick: decay of the 8 channels, sensor count and ageing over the 16 slots, ring write,
// ring sum and scan, then one report per cycle taken. One item at a time; ready
// again the cycle after the last result transfer.
// After reset the block clears the 60-entry ring before taking items.
module mesh_node_presence_monitor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] node_id_i,
  input  logic [7:0]  node_type_i,
  input  logic [7:0]  channel_i,
  input  logic        relayed_i,
  input  logic signed [31:0] skew_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        report_kind_o,
  output logic [1:0]  node_status_o,
  output logic [2:0]  chan_index_o,
  output logic [23:0] chan_activity_o,
  output logic [4:0]  chan_sensors_o,
  output logic [31:0] chan_events_o,
  output logic [31:0] total_events_o,
  output logic [31:0] relayed_events_o,
  output logic [21:0] events_per_min_o,
  output logic [31:0] skew_spread_o,
  output logic [4:0]  type_count_o,
  output logic        last_o
);
  localparam int unsigned SW = mnpm_pkg::SlotW;
  localparam int unsigned CW = mnpm_pkg::ChanW;
  localparam int unsigned WW = mnpm_pkg::WinW;
  localparam int unsigned NS = mnpm_pkg::NodeSlots;
  localparam int unsigned NC = mnpm_pkg::ChannelCount;

  // configuration
  logic [31:0] timeout_q;
  logic [15:0] decay_q, floor_q;
  logic [7:0]  sensor_q, count_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd30000;
      decay_q   <= 16'd63744;
      floor_q   <= 16'd131;
      sensor_q  <= '0;
      count_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mnpm_pkg::RegTimeout: timeout_q <= pwdata;
        mnpm_pkg::RegDecay:   decay_q   <= pwdata[15:0];
        mnpm_pkg::RegFloor:   floor_q   <= pwdata[15:0];
        mnpm_pkg::RegSensor:  sensor_q  <= pwdata[7:0];
        mnpm_pkg::RegCount:   count_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mnpm_pkg::RegTimeout: prdata = timeout_q;
      mnpm_pkg::RegDecay:   prdata = {16'd0, decay_q};
      mnpm_pkg::RegFloor:   prdata = {16'd0, floor_q};
      mnpm_pkg::RegSensor:  prdata = {24'd0, sensor_q};
      mnpm_pkg::RegCount:   prdata = {24'd0, count_q};
      default:              prdata = '0;
    endcase
  end

  // node table
  logic [NS-1:0] valid_q;
  logic [15:0] id_q    [NS];
  logic [7:0]  type_q  [NS];
  logic [7:0]  chan_q  [NS];
  logic [NS-1:0] hasev_q;
  logic [31:0] lev_q   [NS];
  logic [31:0] lbc_q   [NS];
  logic [31:0] skew_q  [NS];

  logic [23:0] act_q [NC];
  logic [31:0] cev_q [NC];
  logic [4:0]  csn_q [NC];
  logic [31:0] total_q, relay_q;
  logic [WW-1:0] head_q;

  // input capture
  logic [1:0]  cmd_q;
  logic [15:0] nid_q;
  logic [7:0]  ntype_q, nchan_q;
  logic        nrel_q;
  logic [31:0] nskew_q, now_q;

  mnpm_pkg::state_e state_q, state_d;
  logic [mnpm_pkg::IdxW-1:0] idx_q;  // scan index, wide enough to reach the end
  logic          found_q, free_ok_q;
  logic [SW-1:0] hit_q, free_q;
  logic [1:0]    status_q;
  logic [21:0]   sum_q;
  logic [31:0]   lo_q, hi_q;
  logic          any_q;
  logic [4:0]    tcnt_q;
  logic [CW:0]   rep_q;
  logic          clr_q;
  logic [WW:0]   clr_idx_q;

  // ring memory
  logic          ram_we;
  logic [WW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;

  mnpm_ram #(.Width(16), .Depth(mnpm_pkg::WindowSlots)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [SW-1:0] si;
  logic [CW-1:0] ci;
  logic [WW-1:0] wi;
  logic [39:0]   prod;
  logic [31:0]   quiet, tmax;
  logic [31:0]   sbias;
  logic          in_acc, out_acc, ev_tally;
  logic [WW-1:0] head_nx;

  assign si      = idx_q[SW-1:0];
  assign ci      = idx_q[CW-1:0];
  assign wi      = idx_q[WW-1:0];
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign prod    = act_q[ci] * decay_q;
  assign tmax    = (lbc_q[si] > lev_q[si]) ? lbc_q[si] : lev_q[si];
  assign quiet   = now_q - tmax;
  assign sbias   = skew_q[si] ^ 32'h8000_0000;
  assign ev_tally = ({24'd0, nchan_q} < 32'(NC));
  assign head_nx = (32'(head_q) == 32'(mnpm_pkg::WindowSlots - 1)) ? '0 : head_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnpm_pkg::S_IDLE:
        if (in_acc) begin
          if (cmd_i == mnpm_pkg::CmdTick) state_d = mnpm_pkg::S_DECAY;
          else if (cmd_i == mnpm_pkg::CmdEvent ||
                   (cmd_i == mnpm_pkg::CmdSync && node_id_i != 16'd0))
            state_d = mnpm_pkg::S_LOOKUP;
          else state_d = mnpm_pkg::S_RING;
        end
      mnpm_pkg::S_LOOKUP: if (32'(idx_q) == NS - 1) state_d = mnpm_pkg::S_UPDATE;
      mnpm_pkg::S_UPDATE: state_d = mnpm_pkg::S_RING;
      mnpm_pkg::S_DECAY:  if (32'(idx_q) == NC - 1) state_d = mnpm_pkg::S_SENSE;
      mnpm_pkg::S_SENSE:  if (32'(idx_q) == NS - 1) state_d = mnpm_pkg::S_AGE;
      mnpm_pkg::S_AGE:    if (32'(idx_q) == NS - 1) state_d = mnpm_pkg::S_RING;
      mnpm_pkg::S_RING:   state_d = mnpm_pkg::S_SUM;
      mnpm_pkg::S_SUM:    if (32'(idx_q) == mnpm_pkg::WindowSlots) state_d = mnpm_pkg::S_SCAN;
      mnpm_pkg::S_SCAN:   if (32'(idx_q) == NS - 1) state_d = mnpm_pkg::S_OUT;
      mnpm_pkg::S_OUT:
        if (out_acc && (cmd_q != mnpm_pkg::CmdTick ||
                        32'(rep_q) == mnpm_pkg::NumReports - 1))
          state_d = mnpm_pkg::S_IDLE;
      default: state_d = mnpm_pkg::S_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready_o  = (state_q == mnpm_pkg::S_IDLE) && !clr_q;
    out_valid_o = (state_q == mnpm_pkg::S_OUT);
    ram_we      = 1'b0;
    ram_addr    = head_q;
    ram_wdata   = '0;
    if (clr_q) begin
      ram_we   = 1'b1;
      ram_addr = clr_idx_q[WW-1:0];
    end else if (state_q == mnpm_pkg::S_RING) begin
      // event bumps current slot (read issued in UPDATE); tick zeroes the new head
      if (cmd_q == mnpm_pkg::CmdTick) begin
        ram_we = 1'b1;
        ram_addr = head_nx;
      end else if (cmd_q == mnpm_pkg::CmdEvent) begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata + 16'd1;
      end
    end else if (state_q == mnpm_pkg::S_SUM) begin
      ram_addr = (32'(idx_q) < mnpm_pkg::WindowSlots) ? wi : '0;
    end
  end

  assign report_kind_o    = (cmd_q == mnpm_pkg::CmdTick);
  assign node_status_o    = status_q;
  assign chan_index_o     = report_kind_o ? 3'(rep_q) : 3'd0;
  assign chan_activity_o  = report_kind_o ? act_q[rep_q[CW-1:0]] : '0;
  assign chan_sensors_o   = report_kind_o ? csn_q[rep_q[CW-1:0]] : '0;
  assign chan_events_o    = report_kind_o ? cev_q[rep_q[CW-1:0]] : '0;
  assign total_events_o   = total_q;
  assign relayed_events_o = relay_q;
  assign events_per_min_o = sum_q;
  assign skew_spread_o    = any_q ? hi_q - lo_q : 32'd0;
  assign type_count_o     = tcnt_q;
  assign last_o           = !report_kind_o || 32'(rep_q) == mnpm_pkg::NumReports - 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mnpm_pkg::S_IDLE;
      valid_q   <= '0;
      hasev_q   <= '0;
      idx_q     <= '0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      head_q    <= '0;
      total_q   <= '0;
      relay_q   <= '0;
      cmd_q     <= '0;
      rep_q     <= '0;
      for (int c = 0; c < NC; c++) begin
        act_q[c] <= '0;
        cev_q[c] <= '0;
        csn_q[c] <= '0;
      end
      for (int s = 0; s < NS; s++) begin
        id_q[s] <= '0; type_q[s] <= '0; chan_q[s] <= '0;
        lev_q[s] <= '0; lbc_q[s] <= '0; skew_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (32'(clr_idx_q) == mnpm_pkg::WindowSlots - 1) clr_q <= 1'b0;
      end
      unique case (state_q)
        mnpm_pkg::S_IDLE: begin
          if (in_acc) begin
            cmd_q <= cmd_i; nid_q <= node_id_i; ntype_q <= node_type_i;
            nchan_q <= channel_i; nrel_q <= relayed_i;
            nskew_q <= skew_ms_i; now_q <= now_ms_i;
            status_q <= mnpm_pkg::StNone;
            idx_q <= '0; found_q <= 1'b0; free_ok_q <= 1'b0;
            rep_q <= '0;
          end
        end
        mnpm_pkg::S_LOOKUP: begin
          if (!found_q && valid_q[si] && id_q[si] == nid_q) begin
            found_q <= 1'b1; hit_q <= si;
          end
          if (!free_ok_q && !valid_q[si]) begin
            free_ok_q <= 1'b1; free_q <= si;
          end
          idx_q <= idx_q + 1'b1;
        end
        mnpm_pkg::S_UPDATE: begin
          logic [SW-1:0] s;
          logic          ok;
          logic [31:0]   lb;
          s  = found_q ? hit_q : free_q;
          ok = found_q || free_ok_q;
          lb = found_q ? lbc_q[s] : 32'd0;
          status_q <= found_q ? mnpm_pkg::StMatched :
                      free_ok_q ? mnpm_pkg::StAdded : mnpm_pkg::StFull;
          if (ok) begin
            valid_q[s] <= 1'b1;
            id_q[s]    <= nid_q;
            type_q[s]  <= ntype_q;
            if (cmd_q == mnpm_pkg::CmdEvent) begin
              chan_q[s]  <= nchan_q;
              hasev_q[s] <= 1'b1;
              lev_q[s]   <= now_q;
              lbc_q[s]   <= (lb == 32'd0) ? now_q : lb;
              if (!found_q) skew_q[s] <= '0;
            end else begin
              lbc_q[s]  <= now_q;
              skew_q[s] <= nskew_q;
              if (!found_q) begin
                chan_q[s] <= '0; hasev_q[s] <= 1'b0; lev_q[s] <= '0;
              end
            end
          end
          if (cmd_q == mnpm_pkg::CmdEvent) begin
            if (ev_tally) begin
              cev_q[nchan_q[CW-1:0]] <= cev_q[nchan_q[CW-1:0]] + 1'b1;
              act_q[nchan_q[CW-1:0]] <= ({1'b0, act_q[nchan_q[CW-1:0]]} + {1'b0, mnpm_pkg::ActOne}
                                         > {1'b0, mnpm_pkg::ActMax}) ? mnpm_pkg::ActMax :
                                        act_q[nchan_q[CW-1:0]] + mnpm_pkg::ActOne;
            end
            total_q <= total_q + 1'b1;
            if (nrel_q) relay_q <= relay_q + 1'b1;
          end
        end
        mnpm_pkg::S_DECAY: begin
          act_q[ci] <= (prod[39:16] < {8'd0, floor_q}) ? 24'd0 : prod[39:16];
          csn_q[ci] <= '0;
          idx_q <= (32'(idx_q) == NC - 1) ? '0 : idx_q + 1'b1;
        end
        mnpm_pkg::S_SENSE: begin
          if (valid_q[si] && type_q[si] == sensor_q && hasev_q[si] &&
              {24'd0, chan_q[si]} < 32'(NC))
            csn_q[chan_q[si][CW-1:0]] <= csn_q[chan_q[si][CW-1:0]] + 1'b1;
          idx_q <= (32'(idx_q) == NS - 1) ? '0 : idx_q + 1'b1;
        end
        mnpm_pkg::S_AGE: begin
          if (valid_q[si] && quiet > timeout_q) valid_q[si] <= 1'b0;
          idx_q <= idx_q + 1'b1;
        end
        mnpm_pkg::S_RING: begin
          if (cmd_q == mnpm_pkg::CmdTick) head_q <= head_nx;
          idx_q <= '0;
          sum_q <= '0;
        end
        mnpm_pkg::S_SUM: begin
          // registered read: data arrives the cycle after its address
          if (idx_q != '0) sum_q <= sum_q + {6'd0, ram_rdata};
          if (32'(idx_q) == mnpm_pkg::WindowSlots) begin
            idx_q <= '0; any_q <= 1'b0; tcnt_q <= '0;
          end else idx_q <= idx_q + 1'b1;
        end
        mnpm_pkg::S_SCAN: begin
          if (valid_q[si]) begin
            if (type_q[si] == count_q) tcnt_q <= tcnt_q + 1'b1;
            if (lbc_q[si] != 32'd0) begin
              any_q <= 1'b1;
              if (!any_q || sbias < lo_q) lo_q <= sbias;
              if (!any_q || sbias > hi_q) hi_q <= sbias;
            end
          end
          idx_q <= idx_q + 1'b1;
        end
        mnpm_pkg::S_OUT: if (out_acc) rep_q <= rep_q + 1'b1;
        default: ;
      endcase
    end
  end
endmodule

>>> sv/mnpm_checker.sv
// Port-level assertions for the monitor core, bound to the top level.
module mnpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        report_kind_o,
  input logic [1:0]  node_status_o,
  input logic [2:0]  chan_index_o,
  input logic        last_o
);
  // no new transfer while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during result");
  // summaries end the item
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_kind_o |-> last_o) else $error("summary not last");
  // channel reports carry status none
  a_tick_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o |-> node_status_o == mnpm_pkg::StNone)
    else $error("tick status");
  // reports advance by channel
  a_chan_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && report_kind_o && !last_o |=>
      out_valid_o && chan_index_o == $past(chan_index_o) + 3'd1) else $error("chan order");
endmodule

bind mesh_node_presence_monitor_core mnpm_checker u_mnpm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .report_kind_o (report_kind_o),
  .node_status_o (node_status_o),
  .chan_index_o  (chan_index_o),
  .last_o        (last_o)
);
